>>> rtl/core/rms_pkg.sv
// Shared widths, constants and types for the rolling mean and deviation block.
`default_nettype none

package rms_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 7;
   localparam int SLOT_BITS   = 6;
   localparam int SUM_BITS    = 23;
   localparam int SQSUM_BITS  = 37;
   localparam int MAG_BITS    = 22;
   localparam int PROD_BITS   = 2 * MAG_BITS;
   localparam int ACC_BITS    = 43;
   localparam int OUT_BITS    = 24;

   localparam logic [COUNT_BITS-1:0] WINDOW_MAX   = 7'd64;
   localparam logic [COUNT_BITS-1:0] WINDOW_MIN   = 7'd2;
   localparam logic [COUNT_BITS-1:0] WINDOW_RESET = 7'd16;

   // serial divider: one quotient bit per cycle
   localparam int DIV_BITS  = 59;
   localparam int DVSR_BITS = 12;
   localparam int STEP_BITS = 6;
   localparam logic [STEP_BITS-1:0] MEAN_STEPS = 6'd30;
   localparam logic [STEP_BITS-1:0] VAR_STEPS  = 6'd59;

   // serial square root: one root bit per cycle
   localparam int RAD_BITS      = 48;
   localparam int ROOT_BITS     = 24;
   localparam int ROOT_CNT_BITS = 5;
   localparam logic [ROOT_CNT_BITS-1:0] ROOT_STEPS = 5'd24;

   localparam logic [2:0] MUL_LAST = 3'd6;

   typedef struct packed {
      logic                  start;
      logic [STEP_BITS-1:0]  steps;
      logic [DVSR_BITS-1:0]  divisor;
      logic [DIV_BITS-1:0]   dividend;
   } div_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQNEW,
      ST_SQOLD,
      ST_SQSUM,
      ST_PREP,
      ST_NMUL,
      ST_MDIV,
      ST_DPREP,
      ST_QDIV,
      ST_ROOT,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/rms_div.sv
// Restoring bit-serial divider, dividend pre-aligned so the quotient lands in the low bits.
`default_nettype none

module rms_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rms_pkg::div_cmd_type              cmd,
   output logic                                   done,
   output logic [rms_pkg::DIV_BITS-1:0]           quotient
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [rms_pkg::STEP_BITS-1:0]     cnt_ff;
   logic [rms_pkg::DIV_BITS-1:0]      work_ff;
   logic [rms_pkg::DVSR_BITS-1:0]     rem_ff;
   logic [rms_pkg::DVSR_BITS-1:0]     dvsr_ff;

   logic [rms_pkg::DVSR_BITS:0]       trial;
   logic [rms_pkg::DVSR_BITS:0]       diff;
   logic                              ge;
   logic [rms_pkg::DVSR_BITS-1:0]     rem_in;
   logic [rms_pkg::DIV_BITS-1:0]      work_in;

   always_comb begin
      trial   = {rem_ff, work_ff[rms_pkg::DIV_BITS-1]};
      diff    = trial - {1'b0, dvsr_ff};
      ge      = (trial >= {1'b0, dvsr_ff});
      // the partial remainder stays below the divisor, so it fits back in DVSR_BITS
      rem_in  = ge ? diff[rms_pkg::DVSR_BITS-1:0] : trial[rms_pkg::DVSR_BITS-1:0];
      work_in = {work_ff[rms_pkg::DIV_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == {{(rms_pkg::STEP_BITS-1){1'b0}}, 1'b1}) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         work_ff <= cmd.dividend;
         rem_ff  <= '0;
         dvsr_ff <= cmd.divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

`default_nettype wire

>>> rtl/core/rms_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
`default_nettype none

module rms_sqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rms_pkg::RAD_BITS-1:0]   radicand,
   output logic                                done,
   output logic [rms_pkg::ROOT_BITS-1:0]       root
);

   localparam int REM_BITS = rms_pkg::ROOT_BITS + 2;

   logic                                 busy_ff;
   logic                                 done_ff;
   logic [rms_pkg::ROOT_CNT_BITS-1:0]    cnt_ff;
   logic [rms_pkg::RAD_BITS-1:0]         rad_ff;
   logic [REM_BITS-1:0]                  rem_ff;
   logic [rms_pkg::ROOT_BITS-1:0]        root_ff;

   logic [REM_BITS+1:0]                  shifted;
   logic [REM_BITS+1:0]                  trial;
   logic [REM_BITS+1:0]                  diff;
   logic                                 ge;

   always_comb begin
      shifted = {rem_ff, rad_ff[rms_pkg::RAD_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      ge      = (shifted >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= rms_pkg::ROOT_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == {{(rms_pkg::ROOT_CNT_BITS-1){1'b0}}, 1'b1}) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[rms_pkg::RAD_BITS-3:0], 2'b00};
         // remainder never exceeds twice the root, so the top two bits drop safely
         rem_ff  <= ge ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
         root_ff <= {root_ff[rms_pkg::ROOT_BITS-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> rtl/core/rolling_mean_std.sv
// Top level: sliding-window mean and sample standard deviation of signed samples.
`default_nettype none

// Keeps the last N samples (N = window length register, 2..64, reset 16; writes
// outside that range are clamped) with a running sum and sum of squares. Each
// request gives one response: samples held, mean (8 fraction bits, truncated toward
// zero) and sample standard deviation (8 fraction bits, floored; std_valid low and
// deviation zero while fewer than two samples are held). One request is processed
// at a time. Each runs a 30-step serial division for the mean and, with two or
// more samples held, a 59-step serial division for the variance and a 24-step
// serial square root, each one quotient or root bit per cycle, amid sequencing
// states. A finished response waits in its output register while the next
// request is taken, so the next request can be taken in the same cycle that the
// response appears; a response still stalled when the next one is ready holds
// the block until taken.
// Writing the window length empties the window; write it only while no request is
// in flight.
module rolling_mean_std (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_en,
   input  wire logic [6:0]          csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [15:0]  req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [6:0]               rsp_held_count,
   output logic signed [23:0]       rsp_window_mean,
   output logic [23:0]              rsp_window_std,
   output logic                     rsp_std_valid
);

   localparam int CB = rms_pkg::COUNT_BITS;

   rms_pkg::state_type state_ff, state_in;

   logic [CB-1:0]                         window_length_ff;
   logic [rms_pkg::SLOT_BITS-1:0]         write_slot_ff;
   logic [CB-1:0]                         fill_count_ff;
   logic signed [rms_pkg::SUM_BITS-1:0]   sum_ff;
   logic [rms_pkg::SQSUM_BITS-1:0]        sqsum_ff;

   logic signed [rms_pkg::SAMPLE_BITS-1:0] ring_mem [rms_pkg::WINDOW_MAX];

   logic signed [rms_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [rms_pkg::SAMPLE_BITS-1:0] old_ff;
   logic                                   full_ff;
   logic [rms_pkg::PROD_BITS-1:0]          prod_ff;
   logic [rms_pkg::ACC_BITS-1:0]           mcand_ff;
   logic [rms_pkg::ACC_BITS-1:0]           acc_ff;
   logic [CB-1:0]                          mplier_ff;
   logic [2:0]                             mcnt_ff;
   logic [rms_pkg::DVSR_BITS-1:0]          m_ff;
   logic                                   neg_ff;
   logic signed [rms_pkg::OUT_BITS-1:0]    mean_ff;
   logic [rms_pkg::OUT_BITS-1:0]           std_ff;
   logic                                   sv_ff;

   logic                                   rsp_valid_ff;
   logic [CB-1:0]                          rsp_count_ff;
   logic signed [rms_pkg::OUT_BITS-1:0]    rsp_mean_ff;
   logic [rms_pkg::OUT_BITS-1:0]           rsp_std_ff;
   logic                                   rsp_sv_ff;

   logic                                   accept;
   logic                                   full;
   logic [CB-1:0]                          slot_next;
   logic [CB-1:0]                          window_in;
   logic [rms_pkg::SAMPLE_BITS-1:0]        new_mag;
   logic [rms_pkg::SAMPLE_BITS-1:0]        old_mag;
   logic [rms_pkg::MAG_BITS-1:0]           sum_mag;
   logic [rms_pkg::MAG_BITS-1:0]           mul_a;
   logic [rms_pkg::PROD_BITS-1:0]          mul_p;
   logic [rms_pkg::ACC_BITS-1:0]           spread;
   logic [2*CB-1:0]                        pair_count;
   logic                                   out_free;
   logic                                   load_out;
   logic                                   sqrt_start;

   rms_pkg::div_cmd_type                   div_cmd;
   logic                                   div_done;
   logic [rms_pkg::DIV_BITS-1:0]           div_quot;
   logic                                   sqrt_done;
   logic [rms_pkg::ROOT_BITS-1:0]          sqrt_root;

   rms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quot)
   );

   rms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quot[rms_pkg::RAD_BITS-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_stall = (state_ff != rms_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_count_ff >= window_length_ff);
   assign slot_next = {1'b0, write_slot_ff} + 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (csr_write_data < rms_pkg::WINDOW_MIN) begin
         window_in = rms_pkg::WINDOW_MIN;
      end else if (csr_write_data > rms_pkg::WINDOW_MAX) begin
         window_in = rms_pkg::WINDOW_MAX;
      end else begin
         window_in = csr_write_data;
      end
   end

   // magnitudes feeding the shared squarer
   always_comb begin
      new_mag    = sample_ff[rms_pkg::SAMPLE_BITS-1] ? rms_pkg::SAMPLE_BITS'(-sample_ff)
                                                     : rms_pkg::SAMPLE_BITS'(sample_ff);
      old_mag    = old_ff[rms_pkg::SAMPLE_BITS-1] ? rms_pkg::SAMPLE_BITS'(-old_ff)
                                                  : rms_pkg::SAMPLE_BITS'(old_ff);
      sum_mag    = sum_ff[rms_pkg::SUM_BITS-1] ? rms_pkg::MAG_BITS'(-sum_ff)
                                               : rms_pkg::MAG_BITS'(sum_ff);
      case (state_ff)
         rms_pkg::ST_SQNEW: mul_a = {{(rms_pkg::MAG_BITS-rms_pkg::SAMPLE_BITS){1'b0}}, new_mag};
         rms_pkg::ST_SQOLD: mul_a = {{(rms_pkg::MAG_BITS-rms_pkg::SAMPLE_BITS){1'b0}}, old_mag};
         default:           mul_a = sum_mag;
      endcase
      mul_p      = mul_a * mul_a;
      pair_count = fill_count_ff * (fill_count_ff - 1'b1);
      // n*sumsq - sum^2, never negative in exact arithmetic
      if ({1'b0, acc_ff} >= prod_ff) begin
         spread = rms_pkg::ACC_BITS'({1'b0, acc_ff} - prod_ff);
      end else begin
         spread = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      div_cmd.start    = 1'b0;
      div_cmd.steps    = rms_pkg::MEAN_STEPS;
      div_cmd.divisor  = {{(rms_pkg::DVSR_BITS-CB){1'b0}}, fill_count_ff};
      div_cmd.dividend = {sum_mag, 8'b0, 29'b0};
      sqrt_start       = 1'b0;
      load_out         = 1'b0;
      case (state_ff)
         rms_pkg::ST_IDLE: begin
            if (accept) state_in = rms_pkg::ST_SQNEW;
         end
         rms_pkg::ST_SQNEW: state_in = rms_pkg::ST_SQOLD;
         rms_pkg::ST_SQOLD: state_in = rms_pkg::ST_SQSUM;
         rms_pkg::ST_SQSUM: state_in = rms_pkg::ST_PREP;
         rms_pkg::ST_PREP: begin
            div_cmd.start = 1'b1;
            state_in      = rms_pkg::ST_NMUL;
         end
         rms_pkg::ST_NMUL: begin
            if (mcnt_ff == rms_pkg::MUL_LAST) state_in = rms_pkg::ST_MDIV;
         end
         rms_pkg::ST_MDIV: begin
            if (div_done) state_in = rms_pkg::ST_DPREP;
         end
         rms_pkg::ST_DPREP: begin
            if (fill_count_ff < rms_pkg::WINDOW_MIN) begin
               state_in = rms_pkg::ST_OUT;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = rms_pkg::VAR_STEPS;
               div_cmd.divisor  = m_ff;
               div_cmd.dividend = {spread, 16'b0};
               state_in         = rms_pkg::ST_QDIV;
            end
         end
         rms_pkg::ST_QDIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = rms_pkg::ST_ROOT;
            end
         end
         rms_pkg::ST_ROOT: begin
            if (sqrt_done) state_in = rms_pkg::ST_OUT;
         end
         rms_pkg::ST_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = rms_pkg::ST_IDLE;
            end
         end
         default: state_in = rms_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // window state and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= rms_pkg::WINDOW_RESET;
         write_slot_ff    <= '0;
         fill_count_ff    <= '0;
         sum_ff           <= '0;
         sqsum_ff         <= '0;
      end else if (csr_write_en) begin
         window_length_ff <= window_in;
         write_slot_ff    <= '0;
         fill_count_ff    <= '0;
         sum_ff           <= '0;
         sqsum_ff         <= '0;
      end else begin
         if (accept) begin
            write_slot_ff <= (slot_next >= window_length_ff) ? '0
                                                             : slot_next[rms_pkg::SLOT_BITS-1:0];
            if (!full) fill_count_ff <= fill_count_ff + 1'b1;
         end
         case (state_ff)
            rms_pkg::ST_SQNEW: begin
               sum_ff <= sum_ff + {{(rms_pkg::SUM_BITS-rms_pkg::SAMPLE_BITS){sample_ff[15]}},
                                   sample_ff}
                                - (full_ff ? {{(rms_pkg::SUM_BITS-rms_pkg::SAMPLE_BITS){old_ff[15]}},
                                              old_ff}
                                           : {rms_pkg::SUM_BITS{1'b0}});
            end
            rms_pkg::ST_SQOLD: sqsum_ff <= sqsum_ff + prod_ff[rms_pkg::SQSUM_BITS-1:0];
            rms_pkg::ST_SQSUM: begin
               // prod_ff holds the square of the sample that drops out
               if (full_ff) sqsum_ff <= sqsum_ff - prod_ff[rms_pkg::SQSUM_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   // sample store: read of the outgoing slot before it is overwritten
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff                  <= ring_mem[write_slot_ff];
         ring_mem[write_slot_ff] <= req_sample;
      end
   end

   // arithmetic datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         rms_pkg::ST_IDLE: begin
            if (accept) begin
               sample_ff <= req_sample;
               full_ff   <= full;
            end
         end
         rms_pkg::ST_SQNEW, rms_pkg::ST_SQOLD, rms_pkg::ST_SQSUM: prod_ff <= mul_p;
         rms_pkg::ST_PREP: begin
            mcand_ff  <= {{(rms_pkg::ACC_BITS-rms_pkg::SQSUM_BITS){1'b0}}, sqsum_ff};
            mplier_ff <= fill_count_ff;
            acc_ff    <= '0;
            mcnt_ff   <= '0;
            m_ff      <= pair_count[rms_pkg::DVSR_BITS-1:0];
            neg_ff    <= sum_ff[rms_pkg::SUM_BITS-1];
         end
         rms_pkg::ST_NMUL: begin
            // n * sumsq, one multiplier bit per cycle
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= {mcand_ff[rms_pkg::ACC_BITS-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[CB-1:1]};
            mcnt_ff   <= mcnt_ff + 1'b1;
         end
         rms_pkg::ST_MDIV: begin
            if (div_done) begin
               mean_ff <= neg_ff ? $signed(-div_quot[rms_pkg::OUT_BITS-1:0])
                                 : $signed(div_quot[rms_pkg::OUT_BITS-1:0]);
            end
         end
         rms_pkg::ST_DPREP: begin
            std_ff <= '0;
            sv_ff  <= 1'b0;
         end
         rms_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               std_ff <= sqrt_root;
               sv_ff  <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_count_ff <= fill_count_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_std_ff   <= std_ff;
         rsp_sv_ff    <= sv_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_held_count  = rsp_count_ff;
   assign rsp_window_mean = rsp_mean_ff;
   assign rsp_window_std  = rsp_std_ff;
   assign rsp_std_valid   = rsp_sv_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= window_length_ff)
      else $error("fill count above window length");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, write_slot_ff} < window_length_ff)
      else $error("write slot outside window");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == rms_pkg::ST_MDIV || state_ff == rms_pkg::ST_QDIV))
      else $error("divider finished outside a wait state");

   a_root_done_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == rms_pkg::ST_ROOT)
      else $error("square root finished outside its wait state");

   a_std_needs_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_std_valid) |-> rsp_held_count >= rms_pkg::WINDOW_MIN)
      else $error("deviation flagged valid with fewer than two samples");
`endif

endmodule

`default_nettype wire

>>> test/tb_rolling_mean_std.sv
// Self-checking testbench for the rolling mean and deviation block.
`default_nettype none

module tb_rolling_mean_std;

   localparam int HOLD_CYCLES   = 1500;
   localparam int SETTLE_CYCLES = 200;
   localparam int LIMIT_CYCLES  = 600000;
   localparam int REPORT_MAX    = 10;

   typedef enum int {
      SHAPE_FULL,
      SHAPE_SMALL,
      SHAPE_TOP,
      SHAPE_BOTTOM,
      SHAPE_NEAR
   } sample_shape_type;

   typedef struct packed {
      logic [rms_pkg::COUNT_BITS-1:0]    held_count;
      logic signed [rms_pkg::OUT_BITS-1:0] mean;
      logic [rms_pkg::OUT_BITS-1:0]      dev;
      logic                              dev_ok;
   } window_stats_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   csr_write_en = 1'b0;
   logic [rms_pkg::COUNT_BITS-1:0]         csr_write_data = '0;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [rms_pkg::SAMPLE_BITS-1:0] req_sample = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [rms_pkg::COUNT_BITS-1:0]         rsp_held_count;
   logic signed [rms_pkg::OUT_BITS-1:0]    rsp_window_mean;
   logic [rms_pkg::OUT_BITS-1:0]           rsp_window_std;
   logic                                   rsp_std_valid;

   // window model
   logic signed [rms_pkg::SAMPLE_BITS-1:0] window_ring [64];
   int                                     ring_slot = 0;
   int                                     held = 0;
   int                                     win_len = rms_pkg::WINDOW_RESET;
   longint                                 win_sum = 0;
   longint unsigned                        win_sqsum = 0;

   logic signed [rms_pkg::SAMPLE_BITS-1:0] pending_samples [$];
   window_stats_type                       expected_stats [$];

   int  send_max = 0;
   int  recv_max = 0;
   int  send_wait = 0;
   int  recv_wait = 0;
   int  fail_count = 0;
   bit  hold_start = 1'b0;
   logic hold_off = 1'b0;

   rolling_mean_std dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_held_count  (rsp_held_count),
      .rsp_window_mean (rsp_window_mean),
      .rsp_window_std  (rsp_window_std),
      .rsp_std_valid   (rsp_std_valid)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Folds one accepted sample into the window and queues the statistics it yields.
   task automatic fold_in_sample(input logic signed [rms_pkg::SAMPLE_BITS-1:0] s);
      longint           old_val;
      longint           mean_full;
      longint unsigned  a;
      longint unsigned  b;
      longint unsigned  d;
      longint unsigned  m;
      longint unsigned  root;
      window_stats_type st;
      if (held >= win_len) begin
         old_val = window_ring[ring_slot];
         win_sum -= old_val;
         win_sqsum -= longint'(old_val * old_val);
      end else begin
         held++;
      end
      window_ring[ring_slot] = s;
      win_sum += longint'(s);
      win_sqsum += longint'(longint'(s) * longint'(s));
      ring_slot = (ring_slot + 1 >= win_len) ? 0 : ring_slot + 1;

      mean_full = (win_sum * 256) / longint'(held);
      if (mean_full > 64'sd8388607) mean_full = 64'sd8388607;
      if (mean_full < -64'sd8388608) mean_full = -64'sd8388608;

      st.held_count = held[rms_pkg::COUNT_BITS-1:0];
      st.mean = mean_full[rms_pkg::OUT_BITS-1:0];
      st.dev = '0;
      st.dev_ok = 1'b0;
      if (held >= 2) begin
         a = longint'(held) * win_sqsum;
         b = win_sum * win_sum;
         d = (a >= b) ? a - b : 0;
         m = longint'(held) * longint'(held - 1);
         root = floor_root((d << 16) / m);
         if (root > 64'hFFFFFF) root = 64'hFFFFFF;
         st.dev = root[rms_pkg::OUT_BITS-1:0];
         st.dev_ok = 1'b1;
      end
      expected_stats.insert(expected_stats.size(), st);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) fold_in_sample(req_sample);
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_valid <= 1'b1;
               req_sample <= pending_samples.pop_front();
               send_wait = $urandom_range(0, send_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor; the drawn stall counts only while a response waits
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected response: count %0d mean %0d std %0d ok %0b",
                           rsp_held_count, rsp_window_mean, rsp_window_std, rsp_std_valid);
            end else begin
               window_stats_type want;
               want = expected_stats.pop_front();
               if (rsp_held_count !== want.held_count || rsp_window_mean !== want.mean ||
                   rsp_window_std !== want.dev || rsp_std_valid !== want.dev_ok) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("mismatch: exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                              want.held_count, want.mean, want.dev, want.dev_ok,
                              rsp_held_count, rsp_window_mean, rsp_window_std,
                              rsp_std_valid);
               end
            end
            recv_wait = $urandom_range(0, recv_max);
         end else if (rsp_valid && recv_wait > 0) begin
            recv_wait--;
         end
      end
      rsp_stall <= hold_off || (recv_wait > 0);
   end

   // long hold-off so the block fills and stalls its requests
   initial begin
      wait (hold_start);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #(LIMIT_CYCLES * 10);
      $display("tb_rolling_mean_std NOT OK");
      $finish;
   end

   function automatic logic [rms_pkg::SAMPLE_BITS-1:0] draw_sample(input bit extremes_only);
      int unsigned      pick;
      sample_shape_type shape;
      pick = $urandom_range(0, 9);
      shape = (pick <= 4) ? sample_shape_type'(pick) : SHAPE_FULL;
      if (extremes_only) shape = ($urandom_range(0, 1) != 0) ? SHAPE_TOP : SHAPE_BOTTOM;
      case (shape)
         SHAPE_SMALL:  return 16'($signed($urandom_range(0, 32)) - 16);
         SHAPE_TOP:    return 16'h7FFF;
         SHAPE_BOTTOM: return 16'h8000;
         SHAPE_NEAR:   return ($urandom_range(0, 1) != 0) ? 16'h7FFF - 16'($urandom_range(0, 7))
                                                            : 16'h8000 + 16'($urandom_range(0, 7));
         default:      return 16'($urandom);
      endcase
   endfunction

   task automatic drain;
      while (pending_samples.size() != 0 || req_valid || expected_stats.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_window(input logic [rms_pkg::COUNT_BITS-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (value < rms_pkg::WINDOW_MIN) win_len = rms_pkg::WINDOW_MIN;
      else if (value > rms_pkg::WINDOW_MAX) win_len = rms_pkg::WINDOW_MAX;
      else win_len = value;
      ring_slot = 0;
      held = 0;
      win_sum = 0;
      win_sqsum = 0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [rms_pkg::COUNT_BITS-1:0] value, input int items,
                            input int gap, input int stall, input bit extremes_only,
                            input bit long_hold);
      write_window(value);
      send_max = gap;
      recv_max = stall;
      if (long_hold) hold_start = 1'b1;
      repeat (items)
         pending_samples.insert(pending_samples.size(), draw_sample(extremes_only));
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window of 16: single sample, extremes, bit patterns, wrap-around
      pending_samples = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                          16'sh5555, 16'shAAAA};
      for (int k = 0; k < 13; k++)
         pending_samples.insert(pending_samples.size(), k[0] ? -16'sh8000 : 16'sh7FFF);
      drain();

      // below-range write clamps to two
      write_window(7'd1);
      pending_samples = '{16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh0000, -16'sh0001};
      drain();

      run_phase(7'd127, 90, 0, 0, 1'b0, 1'b0);
      run_phase(7'd65, 80, 17, 17, 1'b1, 1'b0);
      run_phase(7'd3, 60, 17, 0, 1'b0, 1'b0);
      run_phase(7'd64, 80, 0, 0, 1'b0, 1'b1);
      run_phase(7'($urandom_range(0, 127)), 80, 17, 17, 1'b0, 1'b0);
      run_phase(7'd0, 60, 0, 17, 1'b0, 1'b0);
      run_phase(7'($urandom_range(0, 127)), 80, 17, 17, 1'b0, 1'b0);
      run_phase(7'($urandom_range(2, 8)), 80, 17, 17, 1'b0, 1'b0);
      run_phase(7'd40, 90, 0, 0, 1'b0, 1'b0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_rolling_mean_std OK");
      else
         $display("tb_rolling_mean_std NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/core/rms_pkg.sv
rtl/core/rms_div.sv
rtl/core/rms_sqrt.sv
rtl/core/rolling_mean_std.sv
test/tb_rolling_mean_std.sv
